FILE: rtl/core/wbss_pkg.sv
package wbss_pkg;

    // fixed field widths
    localparam int ADDR_W           = 48;
    localparam int BYTE_W           = 8;
    localparam int PAT_INDEX_W      = 7;
    localparam int PAT_LEN_W        = 8;
    localparam int LEN_W            = 9;
    localparam int PATTERN_DEPTH_DEF = 128;

    // configuration register indexes
    localparam logic CFG_PATTERN_LENGTH = 1'b0;
    localparam logic CFG_REGION_BASE    = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [1:0] STATUS_MULTI  = 2'd2;

    // hit counter codes
    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_MANY = 2'd2;

    // scanned byte handed alongside the cell row to the verdict stage
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] count;
    } scan_stage_t;

endpackage

FILE: rtl/core/wbss_cell.sv
module wbss_cell
    import wbss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic [BYTE_W-1:0] load_value,
    input  logic              load_known,
    input  logic              shift_en,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              prev_match,
    output logic              match
);

    logic [BYTE_W-1:0] expected_reg;
    logic              known_reg;
    logic              match_reg;
    logic              match_next;
    logic              position_ok;

    // pattern position storage
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            expected_reg <= load_value;
            known_reg    <= load_known;
        end
    end

    // extend the prefix handed over by the left neighbor
    assign position_ok = !known_reg || (expected_reg == data_byte);
    assign match_next  = prev_match && position_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

FILE: rtl/core/wbss_verdict.sv
module wbss_verdict
    import wbss_pkg::*;
#(
    parameter int DEPTH = PATTERN_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_stage_t       stage,
    input  logic [DEPTH-1:0]  match_vec,
    input  logic [IDX_W-1:0]  len_m1,
    input  logic              len_zero,
    input  logic [ADDR_W-1:0] region_base,
    output logic              hold,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        match_status,
    output logic [ADDR_W-1:0] match_address
);

    logic [1:0]        hits_reg;
    logic [1:0]        hits_next;
    logic [ADDR_W-1:0] first_reg;
    logic [ADDR_W-1:0] first_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] address_reg;
    logic              fire;
    logic              full_hit;
    logic [ADDR_W-1:0] start_addr;

    // a last byte waits while the result register is still occupied and out_ready is low
    assign hold = stage.valid && stage.last && out_valid_reg && !out_ready;
    assign fire = stage.valid && !hold;

    // window complete at the selected length
    assign full_hit   = !len_zero && match_vec[len_m1];
    assign start_addr = region_base + stage.count
                        - {{(ADDR_W-IDX_W){1'b0}}, len_m1};

    // hit bookkeeping, a first start at address zero is not recorded
    always_comb
    begin
        hits_next  = hits_reg;
        first_next = first_reg;
        if (full_hit)
        begin
            if (hits_reg == HITS_NONE)
            begin
                if (start_addr != '0)
                begin
                    hits_next  = HITS_ONE;
                    first_next = start_addr;
                end
            end
            else
            begin
                hits_next = HITS_MANY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg  <= HITS_NONE;
            first_reg <= '0;
        end
        else if (fire)
        begin
            if (stage.last)
            begin
                hits_reg  <= HITS_NONE;
                first_reg <= '0;
            end
            else
            begin
                hits_reg  <= hits_next;
                first_reg <= first_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && stage.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && stage.last)
        begin
            unique case (hits_next)
                HITS_NONE:
                begin
                    status_reg  <= STATUS_NONE;
                    address_reg <= '0;
                end
                HITS_ONE:
                begin
                    status_reg  <= STATUS_UNIQUE;
                    address_reg <= first_next;
                end
                default:
                begin
                    status_reg  <= STATUS_MULTI;
                    address_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_status  = status_reg;
    assign match_address = address_reg;

endmodule

FILE: rtl/core/wildcard_byte_signature_scan_unit.sv
// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | mode, pattern_index, pattern_value,
//         |           |                      | pattern_known, data_byte, data_last
// out     | out       | out_valid/out_ready  | match_status, match_address
//
// one input transaction per cycle while in_ready is high; the cell row and the
// stage register capture each accepted byte, and the verdict stage then registers
// its outcome in the result register, which a waiting last byte can delay.
// reset clears match bits, counters and the result valid flag; pattern storage
// is undefined until loaded.
// input stalls only while a last byte waits on an occupied, stalled result
// register. configuration writes are always taken.
module wildcard_byte_signature_scan_unit
    import wbss_pkg::*;
#(
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [PAT_INDEX_W-1:0] pattern_index,
    input  logic [BYTE_W-1:0]      pattern_value,
    input  logic                   pattern_known,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   data_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             match_status,
    output logic [ADDR_W-1:0]      match_address
);

    localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

    logic [PAT_LEN_W-1:0]     pattern_length_reg;
    logic [ADDR_W-1:0]        region_base_reg;
    logic [ADDR_W-1:0]        bytes_seen_reg;
    logic                     fresh_reg;
    scan_stage_t              stage_reg;
    scan_stage_t              stage_next;
    logic                     hold;
    logic                     accept;
    logic                     scan_en;
    logic                     load_sel;
    logic [PATTERN_DEPTH-1:0] match_vec;
    logic [LEN_W-1:0]         len_clamped;
    logic [LEN_W-1:0]         len_m1_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = !hold;
    assign accept    = in_valid && in_ready;
    assign scan_en   = accept && mode;
    assign load_sel  = accept && !mode;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= PAT_LEN_W'(1);
            region_base_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PAT_LEN_W-1:0];
                CFG_REGION_BASE:    region_base_reg    <= cfg_data;
                default:            region_base_reg    <= region_base_reg;
            endcase
        end
    end

    // effective length, saturated at the row length
    assign len_clamped = ({1'b0, pattern_length_reg} > LEN_W'(PATTERN_DEPTH))
                         ? LEN_W'(PATTERN_DEPTH) : {1'b0, pattern_length_reg};
    assign len_m1_full = len_clamped - LEN_W'(1);

    // saturating byte counter and fresh-region flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            fresh_reg      <= 1'b0;
        end
        else if (scan_en)
        begin
            fresh_reg <= data_last;
            if (data_last)
            begin
                bytes_seen_reg <= '0;
            end
            else if (bytes_seen_reg != {ADDR_W{1'b1}})
            begin
                bytes_seen_reg <= bytes_seen_reg + ADDR_W'(1);
            end
        end
    end

    // hand the scanned byte to the verdict stage
    always_comb
    begin
        stage_next = stage_reg;
        if (!hold)
        begin
            stage_next.valid = scan_en;
            stage_next.last  = data_last;
            stage_next.count = bytes_seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    // row of partial-match cells
    for (genvar j = 0; j < PATTERN_DEPTH; j++)
    begin : g_cell
        logic prev;
        if (j == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = match_vec[j-1] && !fresh_reg;
        end

        wbss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (load_sel && (32'(pattern_index) == j)),
            .load_value (pattern_value),
            .load_known (pattern_known),
            .shift_en   (scan_en),
            .data_byte  (data_byte),
            .prev_match (prev),
            .match      (match_vec[j])
        );
    end

    wbss_verdict #(
        .DEPTH (PATTERN_DEPTH),
        .IDX_W (IDX_W)
    ) u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage_reg),
        .match_vec     (match_vec),
        .len_m1        (len_m1_full[IDX_W-1:0]),
        .len_zero      (len_clamped == '0),
        .region_base   (region_base_reg),
        .hold          (hold),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_status  (match_status),
        .match_address (match_address)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import wbss_pkg::*;

    localparam int DEPTH = PATTERN_DEPTH_DEF;

    // one input transaction as the driver presents it
    typedef struct {
        logic                   mode;
        logic [PAT_INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]      val;
        logic                   known;
        logic [BYTE_W-1:0]      code_byte;
        logic                   is_last;
    } feed_item_t;

    // one region verdict
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [ADDR_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   mode = 1'b0;
    logic [PAT_INDEX_W-1:0] pattern_index = '0;
    logic [BYTE_W-1:0]      pattern_value = '0;
    logic                   pattern_known = 1'b0;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   data_last = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             match_status;
    logic [ADDR_W-1:0]      match_address;

    wildcard_byte_signature_scan_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .pattern_index (pattern_index),
        .pattern_value (pattern_value),
        .pattern_known (pattern_known),
        .data_byte     (data_byte),
        .data_last     (data_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_status  (match_status),
        .match_address (match_address)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pending transactions and expected verdicts
    feed_item_t feed_q[$];
    verdict_t   verdict_q[$];
    int         errors = 0;
    int         items_planned = 0;
    bit         in_taken = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    // scanner mirror: pattern store, prefix cells, counters, registers
    logic [BYTE_W-1:0] want_byte [DEPTH] = '{default: '0};
    logic              want_known [DEPTH] = '{default: 1'b0};
    logic [DEPTH-1:0]  prefix_hits = '0;
    logic [ADDR_W-1:0] scanned = '0;
    logic [1:0]        hit_tally = HITS_NONE;
    logic [ADDR_W-1:0] first_hit = '0;
    logic [PAT_LEN_W-1:0] cur_len = PAT_LEN_W'(1);
    logic [ADDR_W-1:0] cur_base = '0;

    // what the stimulus has planned for the pattern store
    logic [BYTE_W-1:0] plan_byte [DEPTH] = '{default: '0};
    logic              plan_known [DEPTH] = '{default: 1'b0};
    bit                plan_written [DEPTH] = '{default: 1'b0};

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("tb: mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
        errors++;
    endtask

    task automatic pattern_store_load(input logic [PAT_INDEX_W-1:0] idx,
                                      input logic [BYTE_W-1:0] val, input logic known);
        if (idx < DEPTH)
        begin
            want_byte[idx] = val;
            want_known[idx] = known;
        end
    endtask

    // shift the prefix cells by one code byte, record hits, close the region on last
    task automatic scan_predict_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        logic [DEPTH-1:0]  nxt;
        int                len;
        logic [ADDR_W-1:0] start;
        verdict_t          v;
        nxt[0] = !want_known[0] || want_byte[0] == b;
        for (int j = 1; j < DEPTH; j++)
            nxt[j] = prefix_hits[j-1] && (!want_known[j] || want_byte[j] == b);
        prefix_hits = nxt;
        len = (cur_len > DEPTH) ? DEPTH : int'(cur_len);
        if (len > 0 && prefix_hits[len-1])
        begin
            start = cur_base + scanned - ADDR_W'(len - 1);
            if (hit_tally == HITS_NONE)
            begin
                // a hit starting at address zero is dropped
                if (start != '0)
                begin
                    hit_tally = HITS_ONE;
                    first_hit = start;
                end
            end
            else
                hit_tally = HITS_MANY;
        end
        if (scanned != '1)
            scanned = scanned + 1'b1;
        if (is_last)
        begin
            if (hit_tally == HITS_ONE)
            begin
                v.status = STATUS_UNIQUE;
                v.addr = first_hit;
            end
            else
            begin
                v.status = (hit_tally == HITS_NONE) ? STATUS_NONE : STATUS_MULTI;
                v.addr = '0;
            end
            verdict_q.push_back(v);
            prefix_hits = '0;
            scanned = '0;
            hit_tally = HITS_NONE;
            first_hit = '0;
        end
    endtask

    // input driver: holds a transaction until taken, idles in bursts
    always @(negedge clk)
    begin : feed_driver
        feed_item_t it;
        if (!(in_valid && !in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (feed_q.size() > 0 && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
            begin
                in_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (feed_q.size() > 0)
            begin
                it = feed_q.pop_front();
                in_valid <= 1'b1;
                mode <= it.mode;
                pattern_index <= it.idx;
                pattern_value <= it.val;
                pattern_known <= it.known;
                data_byte <= it.code_byte;
                data_last <= it.is_last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin : ready_driver
        if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_gap = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: check results, feed accepted transactions to the mirror
    always @(posedge clk)
    begin : result_monitor
        verdict_t v;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("unexpected result", match_address, '0);
                else
                begin
                    v = verdict_q.pop_front();
                    if (match_status !== v.status)
                        report_mismatch("status", ADDR_W'(match_status), ADDR_W'(v.status));
                    if (match_address !== v.addr)
                        report_mismatch("address", match_address, v.addr);
                end
            end
            if (in_valid && in_ready)
            begin
                in_taken = 1'b1;
                if (mode)
                    scan_predict_byte(data_byte, data_last);
                else
                    pattern_store_load(pattern_index, pattern_value, pattern_known);
            end
        end
    end

    task automatic push_load(input int idx, input logic [BYTE_W-1:0] val, input logic known);
        feed_item_t it;
        it.mode = 1'b0;
        it.idx = PAT_INDEX_W'(idx);
        it.val = val;
        it.known = known;
        it.code_byte = BYTE_W'($urandom_range(0, 255));
        it.is_last = 1'($urandom_range(0, 1));
        feed_q.push_back(it);
        plan_byte[idx] = val;
        plan_known[idx] = known;
        plan_written[idx] = 1'b1;
        items_planned++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        feed_item_t it;
        it.mode = 1'b1;
        it.idx = PAT_INDEX_W'($urandom_range(0, DEPTH - 1));
        it.val = BYTE_W'($urandom_range(0, 255));
        it.known = 1'($urandom_range(0, 1));
        it.code_byte = b;
        it.is_last = is_last;
        feed_q.push_back(it);
        items_planned++;
    endtask

    // wait until nothing is queued, in flight or expected, then let the pipe drain
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (feed_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PATTERN_LENGTH)
            cur_len = data[PAT_LEN_W-1:0];
        else
            cur_base = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
        return narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom_range(0, 255));
    endfunction

    // random region with zero to two planted copies of the pattern
    task automatic push_region(input int n, input int len_eff, input logic [ADDR_W-1:0] base,
                               input bit narrow);
        logic [BYTE_W-1:0] code [];
        int                copies;
        int                off;
        logic [ADDR_W-1:0] zero_off;
        code = new[n];
        foreach (code[i])
            code[i] = pick_byte(narrow);
        copies = (len_eff > 0 && n >= len_eff) ? $urandom_range(0, 2) : 0;
        zero_off = '0 - base;
        for (int c = 0; c < copies; c++)
        begin
            off = $urandom_range(0, n - len_eff);
            // sometimes plant the copy so that it starts at address zero
            if (c == 0 && zero_off <= ADDR_W'(n - len_eff) && $urandom_range(0, 1) == 1)
                off = int'(zero_off);
            for (int j = 0; j < len_eff; j++)
                if (plan_known[j])
                    code[off + j] = plan_byte[j];
        end
        for (int i = 0; i < n; i++)
        begin
            // pattern loads mixed into the scan
            if ($urandom_range(0, 19) == 0)
                push_load($urandom_range(0, DEPTH - 1), pick_byte(narrow),
                          1'($urandom_range(0, 1)));
            push_byte(code[i], i == n - 1);
        end
    endtask

    initial
    begin : stimulus
        int                len;
        int                len_eff;
        int                n;
        int                phase;
        bit                narrow;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] cfg_word;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: one position, base zero; hit at zero dropped, then unique
        push_load(0, 8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);

        // three positions with a wildcard in the middle, base at the top of the space
        settle();
        write_reg(CFG_PATTERN_LENGTH, ADDR_W'(3));
        write_reg(CFG_REGION_BASE, '1);
        push_load(0, 8'h00, 1'b1);
        push_load(1, 8'hAA, 1'b0);
        push_load(2, 8'hFF, 1'b1);
        // region shorter than the pattern
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // two hits
        push_byte(8'h00, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hFF, 1'b1);
        // first hit wraps to address zero, second one stays unique
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h77, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h88, 1'b0);
        push_byte(8'hFF, 1'b1);

        // zero length never matches
        settle();
        write_reg(CFG_PATTERN_LENGTH, '0);
        push_byte(8'h00, 1'b1);

        // random phases: new registers, new pattern, several regions
        phase = 0;
        while (items_planned < 950)
        begin
            if (phase == 0)
                len = 255;
            else if (phase == 1)
                len = DEPTH;
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 70)
                    len = $urandom_range(1, 6);
                else if (n < 88)
                    len = $urandom_range(7, 24);
                else if (n < 94)
                    len = 0;
                else if (n < 97)
                    len = DEPTH;
                else
                    len = $urandom_range(DEPTH + 1, 255);
            end
            len_eff = (len > DEPTH) ? DEPTH : len;

            n = $urandom_range(0, 9);
            if (n < 4)
                base = ADDR_W'({$urandom, $urandom});
            else if (n < 6)
                base = '0;
            else if (n < 8)
                base = '0 - ADDR_W'($urandom_range(0, 12));
            else
                base = ADDR_W'($urandom_range(0, 12));
            narrow = ($urandom_range(0, 2) == 0);

            settle();
            if (items_planned > 850)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            end

            // upper bits of the length word are don't-care
            cfg_word = ADDR_W'({$urandom, $urandom});
            if ($urandom_range(0, 3) != 0)
                cfg_word = '0;
            cfg_word[PAT_LEN_W-1:0] = PAT_LEN_W'(len);
            write_reg(CFG_PATTERN_LENGTH, cfg_word);
            write_reg(CFG_REGION_BASE, base);

            // every position in use must hold a loaded value before scanning
            for (int j = 0; j < len_eff; j++)
                if (len_eff < DEPTH || !plan_written[j])
                    push_load(j, pick_byte(narrow), 1'($urandom_range(0, 9) < 7));
            repeat ($urandom_range(0, 3))
                push_load($urandom_range(0, DEPTH - 1), pick_byte(narrow),
                          1'($urandom_range(0, 9) < 7));

            if (len_eff >= DEPTH)
                push_region($urandom_range(len_eff - 3, len_eff + 12), len_eff, base, narrow);
            else
                repeat ($urandom_range(2, 6))
                begin
                    if (len_eff == 0)
                        n = $urandom_range(1, 10);
                    else if ($urandom_range(0, 9) < 3)
                        n = $urandom_range(1, (len_eff > 1) ? len_eff - 1 : 1);
                    else
                        n = $urandom_range(len_eff, len_eff + 12);
                    push_region(n, len_eff, base, narrow);
                end
            phase++;
        end

        gap_pct = 0;
        stall_pct = 0;
        settle();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: wildcard_byte_signature_scan_unit.f
rtl/core/wbss_pkg.sv
rtl/core/wbss_cell.sv
rtl/core/wbss_verdict.sv
rtl/core/wildcard_byte_signature_scan_unit.sv
bench/tb.sv
